FILE: sv/fractional_baud_divisor_calc_assert.svh
// Assertion macros shared by the divisor calculator modules.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef FRACTIONAL_BAUD_DIVISOR_CALC_ASSERT_SVH
`define FRACTIONAL_BAUD_DIVISOR_CALC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fbdc_pkg.sv
`default_nettype none

package fbdc_pkg;

    // Field widths.
    localparam int REF_W   = 27;
    localparam int BAUD_W  = 24;
    localparam int NUM_W   = 14;
    localparam int DEN_W   = 15;

    // The ratio is 18.12 fixed point and its raw value stays below 2^30 for valid requests.
    localparam int RATIO_W    = 30;
    localparam int FRAC_SHIFT = 12;
    localparam int HI_SPLIT   = RATIO_W - FRAC_SHIFT;

    // Denominator exponent, quotient bit index and shift amount widths.
    localparam int K_W   = 4;
    localparam int CNT_W = 5;
    localparam int SH_W  = 5;

    localparam logic [K_W-1:0]   K_MAX      = K_W'(15);
    localparam logic [CNT_W-1:0] TOP_SPLIT  = CNT_W'(15);
    localparam logic [SH_W-1:0]  TOP_OFFSET = SH_W'(13);
    localparam logic [SH_W-1:0]  SHIFT_BASE = SH_W'(16);

    localparam logic [REF_W-1:0] REF_CLOCK_RESET = REF_W'(40000000);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             div_step;
        logic [CNT_W-1:0] bit_idx;
        logic             norm;
        logic             reduce_step;
        logic             out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic reduce_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/fbdc_if.sv
`default_nettype none

// Channel that carries one requested baud rate word.
interface fbdc_in_if;
    import fbdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink (input valid, input baud_rate, output ready);
endinterface

// Channel that carries one computed divisor word.
interface fbdc_out_if;
    import fbdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] numerator_minus_one;
    logic [DEN_W-1:0] denominator_minus_one;
    logic             bad_request;

    modport source (
        output valid, output numerator_minus_one, output denominator_minus_one,
        output bad_request, input ready
    );
    modport sink (
        input valid, input numerator_minus_one, input denominator_minus_one,
        input bad_request, output ready
    );
endinterface

`default_nettype wire

FILE: sv/fbdc_datapath.sv
`default_nettype none

`include "fractional_baud_divisor_calc_assert.svh"

module fbdc_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire fbdc_pkg::t_cmd            i_cmd,
    output fbdc_pkg::t_stat                o_stat,
    input  wire logic [fbdc_pkg::BAUD_W-1:0] i_baud_rate,
    input  wire logic [fbdc_pkg::REF_W-1:0]  i_ref_clock_hz,
    output logic [fbdc_pkg::NUM_W-1:0]     o_num_m1,
    output logic [fbdc_pkg::DEN_W-1:0]     o_den_m1,
    output logic                           o_bad
);
    import fbdc_pkg::*;

    logic [BAUD_W-1:0]  r_baud;
    logic [BAUD_W-1:0]  r_rem;
    logic [RATIO_W-1:0] r_quo;
    logic               r_bad;
    logic               r_seen;
    logic [CNT_W-1:0]   r_top;
    logic [NUM_W-1:0]   r_num;
    logic [K_W-1:0]     r_k;
    logic [NUM_W-1:0]   r_out_num;
    logic [DEN_W-1:0]   r_out_den;
    logic               r_out_bad;

    logic [BAUD_W+1:0]  trial;
    logic               qbit;
    logic [SH_W-1:0]    shift_amt;
    logic [RATIO_W-1:0] ratio_shifted;
    logic [SH_W-1:0]    k_wide;

    // Restoring division step: subtract the divisor from the shifted remainder.
    assign trial = {1'b0, r_rem, r_quo[RATIO_W-1]} - {2'b00, r_baud};
    assign qbit  = ~trial[BAUD_W+1];

    // The numerator keeps 14 bits: shift by one at least, more when the ratio is large.
    assign shift_amt     = (r_seen && (r_top >= TOP_SPLIT)) ? (SH_W'(r_top) - TOP_OFFSET)
                                                            : SH_W'(1);
    assign ratio_shifted = r_quo >> shift_amt;
    assign k_wide        = SHIFT_BASE - shift_amt;

    // Datapath registers, updated by the commands from the controller.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_baud <= i_baud_rate;
            r_rem  <= BAUD_W'(i_ref_clock_hz[REF_W-1:HI_SPLIT]);
            r_quo  <= {i_ref_clock_hz[HI_SPLIT-1:0], {FRAC_SHIFT{1'b0}}};
            // A ratio of 2^30 or more shows as a high dividend part at or above the baud.
            r_bad  <= (i_baud_rate == '0)
                   || (BAUD_W'(i_ref_clock_hz[REF_W-1:HI_SPLIT]) >= i_baud_rate);
            r_seen <= 1'b0;
            r_top  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= qbit ? trial[BAUD_W-1:0] : {r_rem[BAUD_W-2:0], r_quo[RATIO_W-1]};
            r_quo <= {r_quo[RATIO_W-2:0], qbit};
            // The first quotient bit that is set marks the top bit of the ratio.
            if (qbit && !r_seen) begin
                r_seen <= 1'b1;
                r_top  <= i_cmd.bit_idx;
            end
        end
        if (i_cmd.norm) begin
            r_num <= ratio_shifted[NUM_W-1:0];
            r_k   <= k_wide[K_W-1:0];
            r_bad <= r_bad || (ratio_shifted[NUM_W-1:0] == '0);
        end
        if (i_cmd.reduce_step) begin
            r_num <= r_num >> 1;
            r_k   <= r_k - K_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_bad <= r_bad;
            r_out_num <= r_bad ? '0 : (r_num - NUM_W'(1));
            r_out_den <= r_bad ? '0 : ((DEN_W'(1) << r_k) - DEN_W'(1));
        end
    end

    // Status back to the controller.
    assign o_stat.bad         = r_bad;
    assign o_stat.reduce_done = r_num[0] || (r_k == '0);

    assign o_num_m1 = r_out_num;
    assign o_den_m1 = r_out_den;
    assign o_bad    = r_out_bad;

    `FBDC_ASSERT_SAME(a_reduce_allowed, i_clk, i_rst_n, i_cmd.reduce_step, (!r_num[0] && (r_k != '0)), "reduction step on odd numerator or unit denominator")
    `FBDC_ASSERT_NEXT(a_norm_width, i_clk, i_rst_n, i_cmd.norm, (r_bad || r_num[NUM_W-1] || (r_k == K_MAX)), "normalized numerator lost its top bit")
    `FBDC_ASSERT_SAME(a_out_nonzero, i_clk, i_rst_n, (i_cmd.out_load && !r_bad), (r_num != '0), "good word with zero numerator")

endmodule

`default_nettype wire

FILE: sv/fbdc_ctrl.sv
`default_nettype none

`include "fractional_baud_divisor_calc_assert.svh"

module fbdc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output fbdc_pkg::t_cmd       o_cmd,
    input  wire fbdc_pkg::t_stat i_stat
);
    import fbdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_NORM,
        S_REDUCE,
        S_FINISH
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             slot_free;

    // The output register can take a word when it is empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_W'(RATIO_W - 1);
                    n_state    = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (i_stat.bad) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_step = 1'b1;
                    o_cmd.bit_idx  = r_cnt;
                    if (r_cnt == '0) begin
                        n_state = S_NORM;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = S_REDUCE;
            end
            S_REDUCE: begin
                if (i_stat.bad || i_stat.reduce_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.reduce_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, bit counter and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `FBDC_ASSERT_NEXT(a_start_divide, i_clk, i_rst_n, (i_in_valid && o_in_ready), ((r_state == S_DIVIDE) && (r_cnt == CNT_W'(RATIO_W - 1))), "accepted word did not start the division")
    `FBDC_ASSERT_NEXT(a_div_to_norm, i_clk, i_rst_n, ((r_state == S_DIVIDE) && (r_cnt == '0) && !i_stat.bad), (r_state == S_NORM), "last quotient bit did not lead to normalization")
    `FBDC_ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, ((r_state == S_FINISH) && slot_free), (r_out_valid && (r_state == S_IDLE)), "finished word not presented")

endmodule

`default_nettype wire

FILE: sv/fractional_baud_divisor_calc.sv
// A request rejected at once skips the division and goes straight to the finish state.
// Otherwise a bit-serial quotient loop of 30 steps runs, then 0 to 13 reduction steps.
// A new word is accepted only in the idle state, not before the previous one is finished;
// it is accepted while the previous result still waits in the output register.
// Reset (synchronous, active low) idles the controller, empties the output
// register and sets the reference clock register to 40000000.
`default_nettype none

module fractional_baud_divisor_calc (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [fbdc_pkg::REF_W-1:0] i_cfg_wr_data,
    fbdc_in_if.sink                         i_in,
    fbdc_out_if.source                      o_out
);
    import fbdc_pkg::*;

    logic [REF_W-1:0] r_ref_clock_hz;
    t_cmd             cmd;
    t_stat            stat;

    // Reference clock configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock_hz <= REF_CLOCK_RESET;
        end else if (i_cfg_wr_en) begin
            r_ref_clock_hz <= i_cfg_wr_data;
        end
    end

    // Sequencer for division, normalization and reduction.
    fbdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Divider, normalizer, reducer and output register.
    fbdc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_baud_rate    (i_in.baud_rate),
        .i_ref_clock_hz (r_ref_clock_hz),
        .o_num_m1       (o_out.numerator_minus_one),
        .o_den_m1       (o_out.denominator_minus_one),
        .o_bad          (o_out.bad_request)
    );

endmodule

`default_nettype wire
